### hw/rtl/jhtmht_pkg.sv
// Package for the jet HT/MHT accumulator: state codes, register indexes,
// saturation limits and the constant function that builds the fine sine table.
// Depends on nothing; used by jet_ht_mht_accumulator.
package jhtmht_pkg;

    localparam int unsigned SIN_FINE_DEPTH = 2049;

    localparam logic [1:0] CFG_ETA_LIMIT   = 2'd0;
    localparam logic [1:0] CFG_PT_LOW_CUT  = 2'd1;
    localparam logic [1:0] CFG_PT_HIGH_CUT = 2'd2;

    localparam logic [6:0]  SAT7  = 7'd127;
    localparam logic [22:0] SAT23 = 23'd8388607;
    localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;

    typedef logic [30:0] sin_fine_t [0:SIN_FINE_DEPTH-1];

    typedef enum logic [14:0] {
        S_IDLE      = 15'h0001,
        S_JET       = 15'h0002,
        S_TRIG_ADDR = 15'h0004,
        S_TRIG_MUL  = 15'h0008,
        S_TRIG_ACC  = 15'h0010,
        S_SQ_X      = 15'h0020,
        S_SQ_Y      = 15'h0040,
        S_SQ_ADD    = 15'h0080,
        S_SQRT      = 15'h0100,
        S_ANG_A     = 15'h0200,
        S_ANG_B     = 15'h0400,
        S_ANG_C     = 15'h0800,
        S_ANG_D     = 15'h1000,
        S_DIV       = 15'h2000,
        S_OUT       = 15'h4000
    } state_t;

    // Restoring shift-and-subtract quotient, used only while building the table.
    function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
        logic [63:0] quo;
        logic [63:0] rem;
        quo = '0;
        rem = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Quarter-wave sine of i/8192 turn in Q30, from an integer Taylor series.
    function automatic sin_fine_t build_sin_fine();
        sin_fine_t          tab;
        logic [63:0]        xv;
        logic [63:0]        tv;
        logic [63:0]        den;
        logic signed [63:0] sv;
        for (int i = 0; i < SIN_FINE_DEPTH; i++) begin
            xv = ((64'(i) * (PI_Q62 >> 20)) >> 24);
            tv = xv;
            sv = $signed(xv);
            for (int n = 1; n <= 9; n++) begin
                tv  = (tv * xv) >> 30;
                tv  = (tv * xv) >> 30;
                den = 64'(2 * n) * 64'(2 * n + 1);
                tv  = udiv64(tv, den);
                if ((n & 1) == 1) begin
                    sv = sv - $signed(tv);
                end else begin
                    sv = sv + $signed(tv);
                end
            end
            if (sv < 0) begin
                sv = 64'sd0;
            end
            if (sv > 64'sd1073741824) begin
                sv = 64'sd1073741824;
            end
            tab[i] = sv[30:0];
        end
        return tab;
    endfunction

endpackage

### hw/rtl/jet_ht_mht_accumulator.sv
// Top level of the jet HT/MHT accumulator: per-jet accumulation and the
// end-of-event square root, angle search and division on one shared datapath.
// Depends on jhtmht_pkg.
//
// Usage. Jets arrive on the s_ channel, one per transfer; the transfer that
// carries last_in_event closes the event and produces exactly one result on
// the m_ channel, after which all event state is cleared. Transfers without
// last_in_event produce no result. The configuration port is a plain write
// port (cfg_wr_en, cfg_index, cfg_wdata) and should be written only while the
// block is idle; an index beyond the register list is ignored.
//
// Timing. s_ready is high only while the sequencer is idle. A jet that misses
// the eta cut or the low pt cut needs only the jet state; a jet above the low
// pt cut also runs the trig states, since the sine and the cosine are each a
// ROM read, a multiply and an accumulate on the one shared multiplier. The end
// of an event adds two squaring passes, a 24-step square root, an angle
// bisection of up to 11 steps (two ROM reads and two multiplies each) and a
// 39-step restoring division.
//
// The result waits in an output register; a stalled receiver holds the
// sequencer in its final state only when a new result is ready to replace an
// unaccepted one. Reset (aresetn low, synchronous) restores the register
// defaults, clears the event state and drops m_valid.
module jet_ht_mht_accumulator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_jet_present,
    input  logic [15:0] s_jet_pt,
    input  logic signed [9:0] s_jet_eta,
    input  logic [11:0] s_jet_phi,
    input  logic        s_last_in_event,
    input  logic [15:0] s_met_pt,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [6:0]  m_jets_in_eta,
    output logic [6:0]  m_jets_above_low,
    output logic [6:0]  m_jets_above_high,
    output logic [22:0] m_ht_sum,
    output logic [22:0] m_all_pt_sum,
    output logic [15:0] m_leading_pt,
    output logic [15:0] m_subleading_pt,
    output logic [22:0] m_mht_magnitude,
    output logic [11:0] m_mht_angle,
    output logic [16:0] m_mht_ht_ratio,
    output logic signed [23:0] m_met_mht_diff
);
    import jhtmht_pkg::*;

    localparam sin_fine_t SIN_FINE = build_sin_fine();

    // Configuration registers.
    logic [8:0]  eta_limit_reg;
    logic [15:0] pt_low_cut_reg, pt_high_cut_reg;

    // Latched input item.
    logic        present_reg, last_reg;
    logic [15:0] pt_reg, met_reg;
    logic signed [9:0] eta_reg;
    logic [11:0] phi_reg;

    // Event state.
    logic [6:0]  count_eta_reg, count_low_reg, count_high_reg;
    logic [22:0] ht_acc_reg, pt_acc_reg;
    logic [15:0] lead_reg, sublead_reg;
    logic signed [23:0] mht_x_acc_reg, mht_y_acc_reg;

    state_t state_reg;
    logic   trig_sel_reg;

    // Shared multiplier and ROM port.
    logic signed [24:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [56:0] mul_p_reg;
    logic [11:0] rom_addr;
    logic [30:0] rom_data_reg;

    // End-of-event working registers.
    logic [47:0] sq_reg, sqrt_res_reg, sqrt_bit_reg;
    logic [5:0]  iter_cnt_reg;
    logic [1:0]  quad_reg;
    logic [23:0] ang_u_reg, ang_v_reg;
    logic [10:0] lo_reg, hi_reg;
    logic signed [56:0] usb_reg;
    logic [23:0] rem_reg;
    logic [38:0] div_num_reg, div_q_reg;

    // Output register.
    logic        m_valid_reg;
    logic [6:0]  out_eta_reg, out_low_reg, out_high_reg;
    logic [22:0] out_ht_reg, out_pt_reg, out_mag_reg;
    logic [15:0] out_lead_reg, out_sublead_reg;
    logic [11:0] out_angle_reg;
    logic [16:0] out_ratio_reg;
    logic signed [23:0] out_diff_reg;

    logic in_fire, out_load;
    assign s_ready  = (state_reg == S_IDLE);
    assign in_fire  = s_valid && s_ready;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_ready);

    // Jet selection.
    logic [9:0] abs_eta;
    logic jet_kept, jet_low, jet_high;
    assign abs_eta  = eta_reg[9] ? 10'(-eta_reg) : 10'(eta_reg);
    assign jet_kept = present_reg && (abs_eta <= {1'b0, eta_limit_reg});
    assign jet_low  = jet_kept && (pt_reg > pt_low_cut_reg);
    assign jet_high = pt_reg > pt_high_cut_reg;

    logic [23:0] pt_sum_w, ht_sum_w;
    assign pt_sum_w = {1'b0, pt_acc_reg} + {8'd0, pt_reg};
    assign ht_sum_w = {1'b0, ht_acc_reg} + {8'd0, pt_reg};

    // Trig lookup: sine when trig_sel is low, cosine (a quarter turn on) when high.
    logic [11:0] phase;
    logic [10:0] trig_idx;
    logic [14:0] trig_mag;
    logic signed [15:0] trig_val;
    assign phase    = trig_sel_reg ? (phi_reg + 12'd1024) : phi_reg;
    assign trig_idx = phase[10] ? (11'd1024 - {1'b0, phase[9:0]}) : {1'b0, phase[9:0]};
    assign trig_mag = 15'((32'(rom_data_reg) + 32'd32768) >> 16);
    assign trig_val = phase[11] ? -$signed({1'b0, trig_mag}) : $signed({1'b0, trig_mag});

    logic signed [19:0] term;
    logic signed [25:0] acc_sel, acc_diff;
    logic signed [23:0] acc_clamped;
    assign term     = mul_p_reg[33:14];
    assign acc_sel  = trig_sel_reg ? 26'(mht_x_acc_reg) : 26'(mht_y_acc_reg);
    assign acc_diff = acc_sel - 26'(term);
    always_comb begin
        if (acc_diff > 26'sd8388607) begin
            acc_clamped = 24'sh7FFFFF;
        end else if (acc_diff < -26'sd8388608) begin
            acc_clamped = 24'sh800000;
        end else begin
            acc_clamped = acc_diff[23:0];
        end
    end

    // Quadrant fold for the angle search.
    logic signed [24:0] x_ext, y_ext, nx_ext, ny_ext;
    logic x_zero, y_zero;
    assign x_ext  = 25'(mht_x_acc_reg);
    assign y_ext  = 25'(mht_y_acc_reg);
    assign nx_ext = -x_ext;
    assign ny_ext = -y_ext;
    assign x_zero = (mht_x_acc_reg == 24'sd0);
    assign y_zero = (mht_y_acc_reg == 24'sd0);

    logic [10:0] mid, idx;
    assign mid = 11'((12'(lo_reg) + 12'(hi_reg)) >> 1);
    assign idx = {mid[9:0], 1'b1};

    // Square root step and saturated magnitude.
    logic [47:0] sqrt_trial;
    assign sqrt_trial = sqrt_res_reg + sqrt_bit_reg;
    logic [22:0] mag_w;
    assign mag_w = (sqrt_res_reg > 48'(SAT23)) ? SAT23 : sqrt_res_reg[22:0];

    // Division step.
    logic [24:0] rem_sh;
    assign rem_sh = {rem_reg, div_num_reg[38]};
    logic [16:0] ratio_w;
    assign ratio_w = (ht_acc_reg == 23'd0) ? 17'd0 :
                     (div_q_reg > 39'd65536) ? 17'd65536 : div_q_reg[16:0];

    always_comb begin
        mul_a    = '0;
        mul_b    = '0;
        rom_addr = '0;
        case (state_reg)
            S_TRIG_ADDR: rom_addr = {trig_idx, 1'b0};
            S_TRIG_MUL: begin
                mul_a = $signed({9'd0, pt_reg});
                mul_b = 32'(trig_val);
            end
            S_SQ_X: begin
                mul_a = x_ext;
                mul_b = 32'(mht_x_acc_reg);
            end
            S_SQ_Y: begin
                mul_a = y_ext;
                mul_b = 32'(mht_y_acc_reg);
            end
            S_ANG_A: rom_addr = {1'b0, idx};
            S_ANG_B: begin
                rom_addr = 12'd2048 - {1'b0, idx};
                mul_a    = $signed({1'b0, ang_u_reg});
                mul_b    = $signed({1'b0, rom_data_reg});
            end
            S_ANG_C: begin
                mul_a = $signed({1'b0, ang_v_reg});
                mul_b = $signed({1'b0, rom_data_reg});
            end
            default: begin
                mul_a    = '0;
                mul_b    = '0;
                rom_addr = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        mul_p_reg    <= mul_a * mul_b;
        rom_data_reg <= SIN_FINE[rom_addr];
    end

    // Configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eta_limit_reg   <= 9'd240;
            pt_low_cut_reg  <= 16'd120;
            pt_high_cut_reg <= 16'd200;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ETA_LIMIT:   eta_limit_reg   <= cfg_wdata[8:0];
                CFG_PT_LOW_CUT:  pt_low_cut_reg  <= cfg_wdata;
                CFG_PT_HIGH_CUT: pt_high_cut_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input latch.
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            present_reg <= s_jet_present;
            pt_reg      <= s_jet_pt;
            eta_reg     <= s_jet_eta;
            phi_reg     <= s_jet_phi;
            last_reg    <= s_last_in_event;
            met_reg     <= s_met_pt;
        end
    end

    // Sequencer and event state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            trig_sel_reg   <= 1'b0;
            count_eta_reg  <= '0;
            count_low_reg  <= '0;
            count_high_reg <= '0;
            ht_acc_reg     <= '0;
            pt_acc_reg     <= '0;
            lead_reg       <= '0;
            sublead_reg    <= '0;
            mht_x_acc_reg  <= '0;
            mht_y_acc_reg  <= '0;
            iter_cnt_reg   <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        state_reg <= S_JET;
                    end
                end
                S_JET: begin
                    trig_sel_reg <= 1'b0;
                    if (jet_kept) begin
                        if (count_eta_reg != SAT7) count_eta_reg <= count_eta_reg + 7'd1;
                        pt_acc_reg <= pt_sum_w[23] ? SAT23 : pt_sum_w[22:0];
                        if (pt_reg > lead_reg) begin
                            sublead_reg <= lead_reg;
                            lead_reg    <= pt_reg;
                        end else if (pt_reg > sublead_reg) begin
                            sublead_reg <= pt_reg;
                        end
                        if (jet_high && count_high_reg != SAT7) begin
                            count_high_reg <= count_high_reg + 7'd1;
                        end
                    end
                    if (jet_low) begin
                        if (count_low_reg != SAT7) count_low_reg <= count_low_reg + 7'd1;
                        ht_acc_reg <= ht_sum_w[23] ? SAT23 : ht_sum_w[22:0];
                        state_reg  <= S_TRIG_ADDR;
                    end else if (last_reg) begin
                        state_reg <= S_SQ_X;
                    end else begin
                        state_reg <= S_IDLE;
                    end
                end
                S_TRIG_ADDR: state_reg <= S_TRIG_MUL;
                S_TRIG_MUL:  state_reg <= S_TRIG_ACC;
                S_TRIG_ACC: begin
                    if (trig_sel_reg) begin
                        mht_x_acc_reg <= acc_clamped;
                        state_reg     <= last_reg ? S_SQ_X : S_IDLE;
                    end else begin
                        mht_y_acc_reg <= acc_clamped;
                        trig_sel_reg  <= 1'b1;
                        state_reg     <= S_TRIG_ADDR;
                    end
                end
                S_SQ_X: state_reg <= S_SQ_Y;
                S_SQ_Y: begin
                    sq_reg    <= mul_p_reg[47:0];
                    state_reg <= S_SQ_ADD;
                end
                S_SQ_ADD: begin
                    sq_reg       <= sq_reg + mul_p_reg[47:0];
                    sqrt_res_reg <= '0;
                    sqrt_bit_reg <= 48'd1 << 46;
                    iter_cnt_reg <= '0;
                    lo_reg       <= '0;
                    // A zero vector has no direction; it takes the first quadrant
                    // and an empty search, so its angle is 0.
                    hi_reg       <= (x_zero && y_zero) ? 11'd0 : 11'd1024;
                    if ((x_zero && y_zero) || (!x_ext[24] && !x_zero && !y_ext[24])) begin
                        quad_reg  <= 2'd0;
                        ang_u_reg <= x_ext[23:0];
                        ang_v_reg <= y_ext[23:0];
                    end else if ((x_ext[24] || x_zero) && !y_ext[24] && !y_zero) begin
                        quad_reg  <= 2'd1;
                        ang_u_reg <= y_ext[23:0];
                        ang_v_reg <= nx_ext[23:0];
                    end else if (x_ext[24] && (y_ext[24] || y_zero)) begin
                        quad_reg  <= 2'd2;
                        ang_u_reg <= nx_ext[23:0];
                        ang_v_reg <= ny_ext[23:0];
                    end else begin
                        quad_reg  <= 2'd3;
                        ang_u_reg <= ny_ext[23:0];
                        ang_v_reg <= x_ext[23:0];
                    end
                    state_reg <= S_SQRT;
                end
                S_SQRT: begin
                    if (sq_reg >= sqrt_trial) begin
                        sq_reg       <= sq_reg - sqrt_trial;
                        sqrt_res_reg <= (sqrt_res_reg >> 1) + sqrt_bit_reg;
                    end else begin
                        sqrt_res_reg <= sqrt_res_reg >> 1;
                    end
                    sqrt_bit_reg <= sqrt_bit_reg >> 2;
                    iter_cnt_reg <= iter_cnt_reg + 6'd1;
                    if (iter_cnt_reg == 6'd23) begin
                        state_reg <= S_ANG_A;
                    end
                end
                S_ANG_A: begin
                    if (lo_reg >= hi_reg) begin
                        rem_reg      <= '0;
                        div_num_reg  <= {mag_w, 16'd0};
                        div_q_reg    <= '0;
                        iter_cnt_reg <= '0;
                        state_reg    <= S_DIV;
                    end else begin
                        state_reg <= S_ANG_B;
                    end
                end
                S_ANG_B: state_reg <= S_ANG_C;
                S_ANG_C: begin
                    usb_reg   <= mul_p_reg;
                    state_reg <= S_ANG_D;
                end
                S_ANG_D: begin
                    // Boundary reached: the direction lies at or past this half step.
                    if (mul_p_reg >= usb_reg) begin
                        lo_reg <= mid + 11'd1;
                    end else begin
                        hi_reg <= mid;
                    end
                    state_reg <= S_ANG_A;
                end
                S_DIV: begin
                    if (rem_sh >= {2'b0, ht_acc_reg}) begin
                        rem_reg   <= 24'(rem_sh - {2'b0, ht_acc_reg});
                        div_q_reg <= {div_q_reg[37:0], 1'b1};
                    end else begin
                        rem_reg   <= rem_sh[23:0];
                        div_q_reg <= {div_q_reg[37:0], 1'b0};
                    end
                    div_num_reg  <= {div_num_reg[37:0], 1'b0};
                    iter_cnt_reg <= iter_cnt_reg + 6'd1;
                    if (iter_cnt_reg == 6'd38) begin
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        count_eta_reg  <= '0;
                        count_low_reg  <= '0;
                        count_high_reg <= '0;
                        ht_acc_reg     <= '0;
                        pt_acc_reg     <= '0;
                        lead_reg       <= '0;
                        sublead_reg    <= '0;
                        mht_x_acc_reg  <= '0;
                        mht_y_acc_reg  <= '0;
                        state_reg      <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_eta_reg     <= count_eta_reg;
            out_low_reg     <= count_low_reg;
            out_high_reg    <= count_high_reg;
            out_ht_reg      <= ht_acc_reg;
            out_pt_reg      <= pt_acc_reg;
            out_lead_reg    <= lead_reg;
            out_sublead_reg <= sublead_reg;
            out_mag_reg     <= mag_w;
            out_angle_reg   <= {quad_reg, 10'd0} + {1'b0, lo_reg};
            out_ratio_reg   <= ratio_w;
            out_diff_reg    <= $signed({8'd0, met_reg}) - $signed({1'b0, mag_w});
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_jets_in_eta     = out_eta_reg;
    assign m_jets_above_low  = out_low_reg;
    assign m_jets_above_high = out_high_reg;
    assign m_ht_sum          = out_ht_reg;
    assign m_all_pt_sum      = out_pt_reg;
    assign m_leading_pt      = out_lead_reg;
    assign m_subleading_pt   = out_sublead_reg;
    assign m_mht_magnitude   = out_mag_reg;
    assign m_mht_angle       = out_angle_reg;
    assign m_mht_ht_ratio    = out_ratio_reg;
    assign m_met_mht_diff    = out_diff_reg;

    // A new result only appears from the final state of the sequence.
    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside the output state");

    a_lead_order: assert property (@(posedge aclk) disable iff (!aresetn)
        lead_reg >= sublead_reg)
        else $error("subleading pt exceeds leading pt");

    a_search_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ANG_B || state_reg == S_ANG_C || state_reg == S_ANG_D)
        |-> (lo_reg < hi_reg && hi_reg <= 11'd1024))
        else $error("angle search bounds out of order");

    a_event_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> (count_eta_reg == 7'd0 && ht_acc_reg == 23'd0 &&
                      mht_x_acc_reg == 24'sd0 && mht_y_acc_reg == 24'sd0))
        else $error("event state not cleared after result");

    a_ratio_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_ratio_reg <= 17'd65536))
        else $error("ratio above saturation limit");

endmodule
